### rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants of the dual cascadable timer
// Operation codes, register sub-indexes and control bit positions.
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int CTRL_W = 12;
    localparam int DATA_W = 32;

    typedef logic [CTRL_W-1:0] t_ctrl;
    typedef logic [DATA_W-1:0] t_word;

    // operation codes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register slot within one timer (low two bits of the index)
    localparam logic [1:0] SUB_CTRL  = 2'd0;
    localparam logic [1:0] SUB_LOAD  = 2'd1;
    localparam logic [1:0] SUB_COUNT = 2'd2;

    // control word bit positions
    localparam int B_CASC  = 11;
    localparam int B_ENALL = 10;
    localparam int B_TINT  = 8;
    localparam int B_ENT   = 7;
    localparam int B_ENIT  = 6;
    localparam int B_LOAD  = 5;
    localparam int B_ARHT  = 4;
    localparam int B_UDT   = 1;

    localparam t_ctrl TINT_MASK = t_ctrl'(1) << B_TINT;

    // one operation as it leaves the input register
    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        logic [2:0] reg_index;
        t_word      write_data;
    } t_op;

endpackage

### rtl/dct_core.sv
// ----------------------------------------------------------------------------
// dct_core: timer register file and next-state logic
// Holds both timers' state and applies one read, write or tick per beat.
// ----------------------------------------------------------------------------
module dct_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dct_pkg::t_op  i_op,
    output dct_pkg::t_word o_read_data,
    output logic          o_irq
);
    import dct_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    t_ctrl                  r_ctrl  [2];
    t_word                  r_load  [2];
    logic [COUNT_WIDTH-1:0] r_count [2];
    logic                   r_halt  [2];

    t_ctrl                  n_ctrl  [2];
    t_word                  n_load  [2];
    logic [COUNT_WIDTH-1:0] n_count [2];
    logic                   n_halt  [2];

    logic                   enall;
    logic                   en      [2];
    logic [COUNT_WIDTH-1:0] ld_val  [2];
    logic                   ts;
    logic [1:0]             sub;
    t_ctrl                  wd;
    logic                   l0, l1;
    logic                   wrap;
    t_word                  rd;

    assign ts  = i_op.reg_index[2];
    assign sub = i_op.reg_index[1:0];
    assign wd  = i_op.write_data[CTRL_W-1:0];
    assign l0  = r_ctrl[0][B_LOAD];
    assign l1  = r_ctrl[1][B_LOAD];

    assign enall     = r_ctrl[0][B_ENALL] | r_ctrl[1][B_ENALL];
    assign en[0]     = enall | r_ctrl[0][B_ENT];
    assign en[1]     = enall | r_ctrl[1][B_ENT];
    assign ld_val[0] = r_load[0][COUNT_WIDTH-1:0];
    assign ld_val[1] = r_load[1][COUNT_WIDTH-1:0];

    always_comb begin
        n_ctrl  = r_ctrl;
        n_load  = r_load;
        n_count = r_count;
        n_halt  = r_halt;
        rd      = '0;
        wrap    = 1'b0;
        if (i_op.valid) begin
            case (i_op.mode)
                MODE_READ: begin
                    case (sub)
                        SUB_CTRL:  rd = t_word'(r_ctrl[ts]);
                        SUB_LOAD:  rd = r_load[ts];
                        SUB_COUNT: rd = t_word'(r_count[ts]);
                        default:   rd = '0;
                    endcase
                end
                MODE_WRITE: begin
                    case (sub)
                        SUB_CTRL: begin
                            // writing 1 to TINT clears it, 0 keeps it
                            n_ctrl[ts] = (wd & ~TINT_MASK) | (r_ctrl[ts] & TINT_MASK & ~wd);
                            if (wd[B_ENT] && !r_ctrl[ts][B_ENT]) begin
                                n_halt[ts] = 1'b0;
                            end
                            if (wd[B_LOAD]) begin
                                n_count[ts] = ld_val[ts];
                                n_halt[ts]  = 1'b0;
                            end
                        end
                        SUB_LOAD: n_load[ts] = i_op.write_data;
                        default: ;
                    endcase
                end
                MODE_TICK: begin
                    if (r_ctrl[0][B_CASC]) begin
                        if (l0) begin
                            n_count[0] = ld_val[0];
                            n_halt[0]  = 1'b0;
                        end
                        if (l1) begin
                            n_count[1] = ld_val[1];
                            n_halt[1]  = 1'b0;
                        end
                        if (!l0 && !l1 && en[0] && !r_halt[0]) begin
                            if (r_count[0] != CNT_MAX) begin
                                n_count[0] = r_count[0] + CNT_ONE;
                            end else begin
                                n_count[0] = '0;
                                if (r_count[1] != CNT_MAX) begin
                                    n_count[1] = r_count[1] + CNT_ONE;
                                end else begin
                                    // full cascade wrap: pair status lives in timer 0
                                    n_count[1]        = '0;
                                    n_ctrl[0][B_TINT] = 1'b1;
                                    if (r_ctrl[0][B_ARHT]) begin
                                        n_count[0] = ld_val[0];
                                        n_count[1] = ld_val[1];
                                        n_halt[0]  = 1'b0;
                                        n_halt[1]  = 1'b0;
                                    end else begin
                                        n_halt[0] = 1'b1;
                                    end
                                end
                            end
                        end
                    end else begin
                        for (int t = 0; t < 2; t++) begin
                            if (r_ctrl[t][B_LOAD]) begin
                                n_count[t] = ld_val[t];
                                n_halt[t]  = 1'b0;
                            end else if (en[t] && !r_halt[t]) begin
                                if (r_ctrl[t][B_UDT]) begin
                                    wrap       = (r_count[t] == '0);
                                    n_count[t] = r_count[t] - CNT_ONE;
                                end else begin
                                    wrap       = (r_count[t] == CNT_MAX);
                                    n_count[t] = r_count[t] + CNT_ONE;
                                end
                                if (wrap) begin
                                    n_ctrl[t][B_TINT] = 1'b1;
                                    if (r_ctrl[t][B_ARHT]) begin
                                        n_count[t] = ld_val[t];
                                        n_halt[t]  = 1'b0;
                                    end else begin
                                        n_halt[t] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_read_data = rd;
    assign o_irq = (n_ctrl[0][B_TINT] & n_ctrl[0][B_ENIT]) |
                   (n_ctrl[1][B_TINT] & n_ctrl[1][B_ENIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 2; t++) begin
                r_ctrl[t]  <= '0;
                r_load[t]  <= '0;
                r_count[t] <= '0;
                r_halt[t]  <= 1'b0;
            end
        end else begin
            r_ctrl  <= n_ctrl;
            r_load  <= n_load;
            r_count <= n_count;
            r_halt  <= n_halt;
        end
    end

    logic tick_now;
    assign tick_now = i_op.valid && (i_op.mode == MODE_TICK);

    // status is raised only by a tick
    a_tint_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_ctrl[0][B_TINT]) && r_ctrl[0][B_TINT]) |-> $past(tick_now))
        else $error("timer 0 status set without a tick");

    // a tick with LOAD set copies the load value
    a_tick_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_now && l0) |=> (r_count[0] == $past(ld_val[0])))
        else $error("timer 0 did not load on tick");

    // a halted timer keeps its count
    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_now && r_halt[0] && !l0) |=> $stable(r_count[0]))
        else $error("halted timer 0 changed its count");

endmodule

### rtl/dual_cascadable_timer.sv
// ----------------------------------------------------------------------------
// dual_cascadable_timer: two 32-bit timers with an optional 64-bit cascade
// Register access and tick beats in, one read/interrupt result per beat out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one beat per operation:
//   i_mode selects read, write or a single tick; i_reg_index picks the word
//   register (0/4 control, 1/5 load, 2/6 counter); i_write_data is the data.
//   Output channel (o_valid / i_stall) returns one beat per input beat with
//   o_read_data (zero unless a read) and o_irq taken after the operation.
//   Throughput is one beat per cycle unless the output stalls: the input
//   register feeds the timer logic, which applies the operation in the
//   cycle it moves into the result register, where o_valid then rises.
//   A stall on the output holds the result register; the input register
//   then fills and o_stall rises, so at most two beats are in flight.
//   Reset (i_rst_n low, synchronous) clears all timer registers and empties
//   both pipeline registers.
// ----------------------------------------------------------------------------
module dual_cascadable_timer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq
);
    import dct_pkg::*;

    t_op   r_op;
    t_op   core_op;
    logic  r_out_valid;
    t_word r_read_data;
    logic  r_irq;
    logic  advance;
    logic  accept;
    t_word core_rd;
    logic  core_irq;

    // move the held beat forward when the result slot is free or draining
    assign advance = r_op.valid && (!r_out_valid || !i_stall);
    assign o_stall = r_op.valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        core_op       = r_op;
        core_op.valid = advance;
    end

    dct_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (core_op),
        .o_read_data (core_rd),
        .o_irq       (core_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_op.valid      <= 1'b1;
                r_op.mode       <= i_mode;
                r_op.reg_index  <= i_reg_index;
                r_op.write_data <= i_write_data;
            end else if (advance) begin
                r_op.valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= core_rd;
            r_irq       <= core_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq       = r_irq;

    // a held beat always leaves into the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat did not reach the result register");

    // stall toward the source only when both registers are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_op.valid && r_out_valid && i_stall))
        else $error("input stalled with a free slot");

    // hold a stalled result beat
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data) && $stable(o_irq)))
        else $error("stalled result beat changed");

endmodule
